/* design/rntp_pkg.sv */
// rntp_pkg: shared types and constants for the radix number token parser
// no dependencies; used by the core and its checker

package rntp_pkg;

  localparam int unsigned CH_W    = 8;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned LEN_W   = 6;
  localparam int unsigned FMT_W   = 3;

  // in_tdata: ch; out_tdata: value, digit_count, pushed_char, zero fill
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 48;
  localparam int unsigned OUT_USED_W  = VALUE_W + COUNT_W + CH_W;

  localparam logic [LEN_W-1:0]   MAX_FIELD_LENGTH = 6'd63;
  localparam logic [COUNT_W-1:0] COUNT_MAX        = 6'd63;

  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CH_W-1:0] CH_UC_A  = 8'h41;
  localparam logic [CH_W-1:0] CH_UC_Z  = 8'h5a;
  localparam logic [CH_W-1:0] CH_LC_A  = 8'h61;
  localparam logic [CH_W-1:0] CH_LC_F  = 8'h66;

  typedef enum logic [FMT_W-1:0] {
    FMT_BIN  = 3'd0,
    FMT_OCT  = 3'd1,
    FMT_UDEC = 3'd2,
    FMT_HEX  = 3'd3,
    FMT_SDEC = 3'd4
  } fmt_t;

  typedef enum logic {
    REG_FORMAT  = 1'b0,
    REG_MAX_LEN = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [CH_W-1:0]    pushed_char;
    logic [COUNT_W-1:0] digit_count;
    logic [VALUE_W-1:0] value;
    logic               pushed_back;
  } result_t;

endpackage

/* design/radix_number_token_parser_core.sv */
// Radix number token parser: the whole parser, a per-character update with an
// output register and a skid register. Depends on rntp_pkg.

// A character item is taken in every cycle while in_tready is high; its
// result, if it closes a token, is offered on the next cycle, or later if a
// stalled result is still waiting ahead of it. in_tready falls only when both
// the output register and the skid register hold results, so the input runs
// at one item per cycle as long as results are taken. The per-character work
// is a shift-add on the 32-bit accumulator plus a compare on the length
// counter, done combinationally.

module radix_number_token_parser_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: ch[7:0]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rntp_pkg::IN_TDATA_W-1:0]   in_tdata,
  // in_tuser: end_of_stream
  input  logic                              in_tuser,
  // out_tdata: value[31:0], digit_count[37:32], pushed_char[45:38], zero[47:46]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rntp_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // out_tuser: pushed_back
  output logic                              out_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [rntp_pkg::LEN_W-1:0]        cfg_data
);
  import rntp_pkg::*;

  logic [FMT_W-1:0]   fmt_r;
  logic [LEN_W-1:0]   max_len_r;
  logic [VALUE_W-1:0] acc_r, acc_nxt;
  logic [COUNT_W-1:0] digits_r, digits_nxt;
  logic [LEN_W-1:0]   left_r, left_nxt;
  logic               neg_r, neg_nxt;
  logic               start_r, start_nxt;

  result_t out_r, skid_r, res;
  logic    out_v_r, skid_v_r;
  logic    emit;

  logic               in_fire, out_fire, eos;
  logic [CH_W-1:0]    raw, c;
  logic [3:0]         base_m1;
  logic               is_hex, is_minus, is_dec, is_af, d_ok;
  logic [3:0]         d;
  logic [LEN_W-1:0]   left_eff, left_dec;
  logic               limit_hit;
  logic [VALUE_W-1:0] acc_mul, acc_dig, emit_acc;
  logic [COUNT_W-1:0] digits_inc, emit_digits;
  logic               emit_neg;

  assign cfg_ready = 1'b1;
  assign in_tready = !skid_v_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;

  assign raw = in_tdata[CH_W-1:0];
  assign eos = in_tuser;
  assign c   = (raw >= CH_UC_A && raw <= CH_UC_Z) ? (raw | 8'h20) : raw;

  always_comb begin
    unique case (fmt_r)
      FMT_BIN: base_m1 = 4'd1;
      FMT_OCT: base_m1 = 4'd7;
      FMT_HEX: base_m1 = 4'd15;
      default: base_m1 = 4'd9;
    endcase
  end

  assign is_hex   = (fmt_r == FMT_HEX);
  assign is_minus = start_r && (fmt_r == FMT_SDEC) && (raw == CH_MINUS);
  assign is_dec   = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_af    = is_hex && (c >= CH_LC_A) && (c <= CH_LC_F);
  assign d        = is_dec ? c[3:0] : (c[3:0] + 4'd9);
  assign d_ok     = (is_dec || is_af) && (d <= base_m1);

  // length counter, loaded when a token's first character arrives
  assign left_eff  = start_r ? ((max_len_r > MAX_FIELD_LENGTH) ? MAX_FIELD_LENGTH : max_len_r)
                             : left_r;
  assign left_dec  = (left_eff != '0) ? (left_eff - 1'b1) : left_eff;
  assign limit_hit = (left_eff == 6'd1);

  always_comb begin
    unique case (fmt_r)
      FMT_BIN: acc_mul = {acc_r[VALUE_W-2:0], 1'b0};
      FMT_OCT: acc_mul = {acc_r[VALUE_W-4:0], 3'b000};
      FMT_HEX: acc_mul = {acc_r[VALUE_W-5:0], 4'b0000};
      default: acc_mul = {acc_r[VALUE_W-4:0], 3'b000} + {acc_r[VALUE_W-2:0], 1'b0};
    endcase
  end

  assign acc_dig    = acc_mul + {{(VALUE_W-4){1'b0}}, d};
  assign digits_inc = (digits_r == COUNT_MAX) ? digits_r : (digits_r + 1'b1);

  always_comb begin
    emit        = 1'b0;
    emit_acc    = acc_r;
    emit_digits = digits_r;
    emit_neg    = neg_r;
    res.pushed_back = 1'b0;
    res.pushed_char = '0;
    acc_nxt    = acc_r;
    digits_nxt = digits_r;
    left_nxt   = left_r;
    neg_nxt    = neg_r;
    start_nxt  = start_r;
    if (in_fire) begin
      if (eos) begin
        emit = 1'b1;
      end else if (is_minus) begin
        neg_nxt   = 1'b1;
        start_nxt = 1'b0;
        left_nxt  = left_dec;
        emit      = limit_hit;
        emit_neg  = 1'b1;
      end else if (!d_ok) begin
        emit            = 1'b1;
        res.pushed_back = 1'b1;
        res.pushed_char = c;
      end else begin
        acc_nxt     = acc_dig;
        digits_nxt  = digits_inc;
        left_nxt    = left_dec;
        start_nxt   = 1'b0;
        emit        = limit_hit;
        emit_acc    = acc_dig;
        emit_digits = digits_inc;
      end
      if (emit) begin
        acc_nxt    = '0;
        digits_nxt = '0;
        left_nxt   = '0;
        neg_nxt    = 1'b0;
        start_nxt  = 1'b1;
      end
    end
    res.value       = emit_neg ? (~emit_acc + 1'b1) : emit_acc;
    res.digit_count = emit_digits;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r     <= FMT_SDEC;
      max_len_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_FORMAT:  fmt_r     <= cfg_data[FMT_W-1:0];
        REG_MAX_LEN: max_len_r <= cfg_data;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      digits_r <= '0;
      left_r   <= '0;
      neg_r    <= 1'b0;
      start_r  <= 1'b1;
    end else begin
      acc_r    <= acc_nxt;
      digits_r <= digits_nxt;
      left_r   <= left_nxt;
      neg_r    <= neg_nxt;
      start_r  <= start_nxt;
    end
  end

  // output register with a skid stage behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_fire) begin
        skid_v_r <= 1'b0;
      end
    end else if (emit) begin
      if (out_v_r && !out_fire) begin
        skid_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (emit) begin
      if (out_v_r && !out_fire) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_r.pushed_back;
  assign out_tdata  = {{(OUT_TDATA_W-OUT_USED_W){1'b0}},
                       out_r.pushed_char, out_r.digit_count, out_r.value};

endmodule

/* design/rntp_checker.sv */
// rntp_checker: port-level assertions for radix_number_token_parser_core
// depends on rntp_pkg; attached to the core by the bind at the end

module rntp_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [rntp_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tuser
);
  import rntp_pkg::*;

  logic [VALUE_W-1:0] value;
  logic [COUNT_W-1:0] digit_count;
  logic [CH_W-1:0]    pushed_char;

  assign value       = out_tdata[VALUE_W-1:0];
  assign digit_count = out_tdata[VALUE_W+COUNT_W-1:VALUE_W];
  assign pushed_char = out_tdata[OUT_USED_W-1:VALUE_W+COUNT_W];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled item changed");

  a_no_char_unless_pushed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> pushed_char == '0)
    else $error("pushed_char set without pushed_back");

  a_pushed_lowercase: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> !(pushed_char >= CH_UC_A && pushed_char <= CH_UC_Z))
    else $error("pushed_char not lowercased");

  a_no_digits_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && digit_count == '0 |-> value == '0)
    else $error("value without digits");

endmodule

bind radix_number_token_parser_core rntp_checker u_rntp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

/* test/radix_number_token_parser_core_tb.sv */
// radix_number_token_parser_core_tb: self-checking bench for the radix number token parser
// streams characters into the core, predicts each token result and checks it field by field
// depends on rntp_pkg and radix_number_token_parser_core
`timescale 1ns / 100ps

module radix_number_token_parser_core_tb;
  import rntp_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 6;
  localparam logic [FMT_W-1:0] FMT_ALIAS_TOP = 3'd7;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_HIGH_LO = 8'h80;

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [LEN_W-1:0] cfg_data = '0;

  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_errors = 0;

  // shadow of the parser
  logic [FMT_W-1:0] fmt_reg = FMT_SDEC;
  logic [LEN_W-1:0] len_reg = '0;
  logic [VALUE_W-1:0] token_acc = '0;
  logic [COUNT_W-1:0] token_digits = '0;
  logic [LEN_W-1:0] token_chars_left = '0;
  bit token_neg = 1'b0;
  bit token_fresh = 1'b1;
  result_t tokens_due[$];
  result_t want;

  radix_number_token_parser_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int base_of(input logic [FMT_W-1:0] f);
    case (f)
      FMT_BIN: return 2;
      FMT_OCT: return 8;
      FMT_HEX: return 16;
      default: return 10;
    endcase
  endfunction

  task automatic emit_token(input bit pb, input logic [CH_W-1:0] pc);
    result_t r;
    r.value = token_neg ? (32'd0 - token_acc) : token_acc;
    r.digit_count = token_digits;
    r.pushed_back = pb;
    r.pushed_char = pb ? pc : '0;
    tokens_due.push_back(r);
    token_acc = '0;
    token_digits = '0;
    token_chars_left = '0;
    token_neg = 1'b0;
    token_fresh = 1'b1;
  endtask

  // true when this character uses up the length limit
  function automatic bit count_char();
    if (token_chars_left == 0) return 1'b0;
    token_chars_left = token_chars_left - 1'b1;
    return token_chars_left == 0;
  endfunction

  task automatic parse_char(input logic [CH_W-1:0] c, input bit eos);
    logic [CH_W-1:0] lc;
    int b;
    int d;
    if (eos) begin
      emit_token(1'b0, '0);
      return;
    end
    lc = (c >= CH_UC_A && c <= CH_UC_Z) ? c + (CH_LC_A - CH_UC_A) : c;
    b = base_of(fmt_reg);
    if (token_fresh) begin
      token_fresh = 1'b0;
      token_chars_left = (len_reg > MAX_FIELD_LENGTH) ? MAX_FIELD_LENGTH : len_reg;
      if (fmt_reg == FMT_SDEC && c == CH_MINUS) begin
        token_neg = 1'b1;
        if (count_char()) emit_token(1'b0, '0);
        return;
      end
    end
    if (lc >= CH_ZERO && lc <= CH_NINE) d = int'(lc - CH_ZERO);
    else if (b == 16 && lc >= CH_LC_A && lc <= CH_LC_F) d = int'(lc - CH_LC_A) + 10;
    else d = -1;
    if (d >= b) d = -1;
    if (d < 0) begin
      emit_token(1'b1, lc);
      return;
    end
    token_acc = token_acc * 32'(b) + 32'(d);
    if (token_digits < COUNT_MAX) token_digits = token_digits + 1'b1;
    if (count_char()) emit_token(1'b0, '0);
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("%t mismatch in %s: got %h, expected %h (result %0d)",
             $realtime, field, got, exp_val, n_checked);
    n_errors++;
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (tokens_due.size() == 0) begin
        report_mismatch("unexpected result value", out_tdata[31:0], '0);
      end else begin
        want = tokens_due.pop_front();
        if (out_tdata[31:0] !== want.value)
          report_mismatch("value", out_tdata[31:0], want.value);
        if (out_tdata[37:32] !== want.digit_count)
          report_mismatch("digit_count", 32'(out_tdata[37:32]), 32'(want.digit_count));
        if (out_tdata[45:38] !== want.pushed_char)
          report_mismatch("pushed_char", 32'(out_tdata[45:38]), 32'(want.pushed_char));
        if (out_tuser !== want.pushed_back)
          report_mismatch("pushed_back", 32'(out_tuser), 32'(want.pushed_back));
      end
      n_checked++;
    end
  end

  task automatic send_item(input logic [CH_W-1:0] c, input bit eos);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = c;
    in_tuser = eos;
    do @(posedge clk); while (!in_tready);
    parse_char(c, eos);
    n_sent++;
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [LEN_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_FORMAT) fmt_reg = data[FMT_W-1:0];
    else len_reg = data;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [CH_W-1:0] digit_char(input int b);
    int d;
    d = $urandom_range(b - 1);
    if (d < 10) return CH_ZERO + CH_W'(d);
    return ($urandom_range(1) ? CH_LC_A : CH_UC_A) + CH_W'(d - 10);
  endfunction

  task automatic send_token();
    int kind;
    int n_dig;
    int b;
    kind = $urandom_range(99);
    if (kind < 12) begin
      send_item(CH_W'($urandom_range(255)), 1'b0);
      return;
    end
    if (kind < 15) begin
      send_item(CH_W'($urandom_range(255)), 1'b1);
      return;
    end
    b = base_of(fmt_reg);
    if ($urandom_range(2) == 0) send_item(CH_MINUS, 1'b0);
    n_dig = ($urandom_range(24) == 0) ? $urandom_range(64, 72) : $urandom_range(0, 12);
    repeat (n_dig) send_item(digit_char(b), 1'b0);
    case ($urandom_range(6))
      0: send_item(CH_W'($urandom_range(255)), 1'b1);
      1: send_item(CH_SPACE, 1'b0);
      2: send_item(CH_W'($urandom_range(255)), 1'b0);
      3: send_item(CH_W'($urandom_range(CH_HIGH_LO, 255)), 1'b0);
      4: send_item(CH_W'($urandom_range(CH_NINE + 1, CH_LC_A - 1)), 1'b0);
      5: send_item(CH_MINUS, 1'b0);
      default: ;
    endcase
  endtask

  task automatic test_signed_defaults();
    send_item(CH_MINUS, 1'b0);
    send_item("4", 1'b0);
    send_item("2", 1'b0);
    send_item(CH_SPACE, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'ha5, 1'b1);
    wait_results_drained();
  endtask

  task automatic test_radix_formats();
    cfg_write(REG_FORMAT, LEN_W'(FMT_HEX));
    cfg_write(REG_MAX_LEN, '0);
    send_item("F", 1'b0);
    send_item("f", 1'b0);
    send_item("9", 1'b0);
    send_item(":", 1'b0);
    wait_results_drained();
    cfg_write(REG_FORMAT, LEN_W'(FMT_ALIAS_TOP));
    send_item("9", 1'b0);
    send_item("a", 1'b0);
    wait_results_drained();
    cfg_write(REG_FORMAT, LEN_W'(FMT_OCT));
    send_item("7", 1'b0);
    send_item("8", 1'b0);
    wait_results_drained();
  endtask

  task automatic test_length_limit();
    cfg_write(REG_FORMAT, LEN_W'(FMT_SDEC));
    cfg_write(REG_MAX_LEN, 6'd1);
    send_item(CH_MINUS, 1'b0);
    wait_results_drained();
    cfg_write(REG_FORMAT, LEN_W'(FMT_BIN));
    cfg_write(REG_MAX_LEN, 6'd3);
    send_item("1", 1'b0);
    send_item("0", 1'b0);
    send_item("1", 1'b0);
    wait_results_drained();
  endtask

  task automatic test_format_switch();
    cfg_write(REG_FORMAT, LEN_W'(FMT_UDEC));
    cfg_write(REG_MAX_LEN, '0);
    send_item("1", 1'b0);
    send_item("2", 1'b0);
    wait_results_drained();
    cfg_write(REG_FORMAT, LEN_W'(FMT_HEX));
    send_item("a", 1'b0);
    send_item(8'h5a, 1'b1);
    wait_results_drained();
  endtask

  task automatic test_random_stream(input int in_idle, input int out_idle, input int count);
    int stop_at;
    int seg_end;
    logic [FMT_W-1:0] f;
    logic [LEN_W-1:0] len;
    in_idle_pct = in_idle;
    out_idle_pct = out_idle;
    stop_at = n_sent + count;
    while (n_sent < stop_at) begin
      wait_results_drained();
      f = ($urandom_range(3) == 0) ? FMT_W'($urandom_range(7)) : FMT_W'($urandom_range(4));
      case ($urandom_range(5))
        0, 1: len = '0;
        2: len = MAX_FIELD_LENGTH;
        3: len = 6'd1;
        default: len = LEN_W'($urandom_range(2, 16));
      endcase
      cfg_write(REG_FORMAT, LEN_W'(f));
      cfg_write(REG_MAX_LEN, len);
      seg_end = n_sent + $urandom_range(40, 90);
      while (n_sent < seg_end && n_sent < stop_at) send_token();
    end
    wait_results_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_signed_defaults();
    test_radix_formats();
    test_length_limit();
    test_format_switch();
    test_random_stream(30, 66, 470);
    test_random_stream(66, 30, 470);
    test_random_stream(0, 0, 470);
    wait_results_drained();
    $display("covered %0d items over formats 0-7 and limits 0-63 with both sides stalling",
             n_sent);
    $display("%0d results checked, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("radix_number_token_parser_core_tb: done, clean");
    end else begin
      $display("radix_number_token_parser_core_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", tokens_due.size());
    $display("radix_number_token_parser_core_tb: done, errors");
    $finish;
  end

endmodule

/* files.f */
design/rntp_pkg.sv
design/radix_number_token_parser_core.sv
design/rntp_checker.sv
test/radix_number_token_parser_core_tb.sv
